// ===== hw/rtl/nwld_pkg.sv =====
// ----------------------------------------------------------------------------
// nwld_pkg
// Types, commands and the code word table shared by the decoder modules.
// ----------------------------------------------------------------------------
package nwld_pkg;

    localparam int CODE_COUNT = 26;
    localparam int CODE_IDX_W = 5;

    localparam logic [7:0] SLASH_BYTE   = 8'h2F;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] UPPER_A_BYTE = 8'h41;
    localparam logic [7:0] UPPER_Z_BYTE = 8'h5A;
    localparam logic [7:0] LOWER_A_BYTE = 8'h61;
    localparam logic [7:0] LOWER_Z_BYTE = 8'h7A;

    // command codes from front to back
    localparam logic [1:0] OP_EOT    = 2'd0;
    localparam logic [1:0] OP_SLASH  = 2'd1;
    localparam logic [1:0] OP_LETTER = 2'd2;
    localparam logic [1:0] OP_OTHER  = 2'd3;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       overflow_error;
    } result_t;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] letter;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

    // right-justified text, first letter in the highest used byte
    localparam logic [63:0] CODE_TEXT [0:CODE_COUNT-1] = '{
        64'("ALFA"), 64'("BRAVO"), 64'("CHARLIE"), 64'("DELTA"), 64'("ECHO"),
        64'("FOXTROT"), 64'("GOLF"), 64'("HOTEL"), 64'("INDIA"), 64'("JULIETT"),
        64'("KILO"), 64'("LIMA"), 64'("MIKE"), 64'("NOVEMBER"), 64'("OSCAR"),
        64'("PAPA"), 64'("QUEBEC"), 64'("ROMEO"), 64'("SIERRA"), 64'("TANGO"),
        64'("UNIFORM"), 64'("VICTOR"), 64'("WHISKEY"), 64'("XRAY"),
        64'("YANKEE"), 64'("ZULU")
    };

    localparam logic [3:0] CODE_LENS [0:CODE_COUNT-1] = '{
        4'd4, 4'd5, 4'd7, 4'd5, 4'd4, 4'd7, 4'd4, 4'd5, 4'd5, 4'd7, 4'd4, 4'd4,
        4'd4, 4'd8, 4'd5, 4'd4, 4'd6, 4'd5, 4'd6, 4'd5, 4'd7, 4'd6, 4'd7, 4'd4,
        4'd6, 4'd4
    };

    // low five bits of letter pos of code word x (pos below its length)
    function automatic logic [4:0] code_letter(input int x, input logic [2:0] pos);
        logic [63:0] w;
        logic [3:0]  sh;
        w  = CODE_TEXT[x];
        sh = CODE_LENS[x] - 4'd1 - {1'b0, pos};
        return w[{sh[2:0], 3'b000} +: 5];
    endfunction

endpackage

// ===== hw/rtl/nwld_fifo.sv =====
// ----------------------------------------------------------------------------
// nwld_fifo
// Short command queue between the classifier front and the word back end.
// ----------------------------------------------------------------------------
module nwld_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             fifo_full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             fifo_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign fifo_full  = (count_reg == CW'(DEPTH));
    assign fifo_empty = (count_reg == '0);
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/nwld_front.sv =====
// ----------------------------------------------------------------------------
// nwld_front
// Accepts text bytes, drops the byte after a slash, classifies the rest.
// ----------------------------------------------------------------------------
module nwld_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  nwld_pkg::item_t item,
    input  logic           cmd_full,
    output logic           full,
    output logic           cmd_push,
    output nwld_pkg::cmd_t cmd
);

    import nwld_pkg::*;

    logic accept;
    logic is_letter;
    logic skip_reg, skip_next;

    assign accept    = push && !full;
    assign full      = cmd_full;
    assign is_letter = ((item.in_char >= UPPER_A_BYTE) && (item.in_char <= UPPER_Z_BYTE))
                    || ((item.in_char >= LOWER_A_BYTE) && (item.in_char <= LOWER_Z_BYTE));

    always_comb
    begin
        skip_next  = skip_reg;
        cmd_push   = 1'b0;
        cmd.letter = item.in_char[4:0];
        cmd.op     = OP_OTHER;
        if (accept)
        begin
            if (item.end_of_text)
            begin
                cmd_push  = 1'b1;
                cmd.op    = OP_EOT;
                skip_next = 1'b0;
            end
            else if (skip_reg)
            begin
                skip_next = 1'b0;
            end
            else if (item.in_char == SLASH_BYTE)
            begin
                cmd_push  = 1'b1;
                cmd.op    = OP_SLASH;
                skip_next = 1'b1;
            end
            else if (is_letter)
            begin
                cmd_push = 1'b1;
                cmd.op   = OP_LETTER;
            end
            else
            begin
                cmd_push = 1'b1;
                cmd.op   = OP_OTHER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg <= 1'b0;
        end
        else
        begin
            skip_reg <= skip_next;
        end
    end

endmodule

// ===== hw/rtl/nwld_back.sv =====
// ----------------------------------------------------------------------------
// nwld_back
// Runs the 26 code word compares per letter and drives the result register.
// ----------------------------------------------------------------------------
module nwld_back #(
    parameter int MAX_WORD_LETTERS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_empty,
    input  nwld_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    input  logic              pop,
    output logic              empty,
    output nwld_pkg::result_t result
);

    import nwld_pkg::*;

    localparam int CW = $clog2(MAX_WORD_LETTERS + 1);

    logic [CW-1:0]         count_reg, count_next;
    logic [CODE_COUNT-1:0] live_reg, live_next;
    logic [CODE_COUNT-1:0] matched_reg, matched_next;
    logic                  halted_reg, halted_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg, out_next;
    logic [CW-1:0]         count_inc;
    logic [CODE_IDX_W-1:0] first_idx;
    logic                  emit;
    result_t               emit_data;

    assign empty     = !out_valid_reg;
    assign result    = out_reg;
    assign cmd_pop   = !cmd_empty && (!out_valid_reg || pop);
    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        first_idx = '0;
        for (int x = CODE_COUNT - 1; x >= 0; x--)
        begin
            if (matched_reg[x])
            begin
                first_idx = CODE_IDX_W'(x);
            end
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        live_next    = live_reg;
        matched_next = matched_reg;
        halted_next  = halted_reg;
        emit         = 1'b0;
        emit_data    = '{out_char: NEWLINE_BYTE, overflow_error: 1'b0};
        if (cmd_pop)
        begin
            if (cmd.op == OP_EOT)
            begin
                emit         = 1'b1;
                count_next   = '0;
                live_next    = '1;
                matched_next = '0;
                halted_next  = 1'b0;
            end
            else if (!halted_reg)
            begin
                case (cmd.op)
                    OP_SLASH:
                    begin
                        emit = 1'b1;
                    end
                    OP_LETTER:
                    begin
                        for (int x = 0; x < CODE_COUNT; x++)
                        begin
                            if (live_reg[x])
                            begin
                                if ((count_reg < CW'(CODE_LENS[x]))
                                    && (cmd.letter == code_letter(x, count_reg[2:0])))
                                begin
                                    if (count_inc == CW'(CODE_LENS[x]))
                                    begin
                                        matched_next[x] = 1'b1;
                                        live_next[x]    = 1'b0;
                                    end
                                end
                                else
                                begin
                                    live_next[x] = 1'b0;
                                end
                            end
                        end
                        count_next = count_inc;
                        if (count_inc >= CW'(MAX_WORD_LETTERS))
                        begin
                            emit         = 1'b1;
                            emit_data    = '{out_char: 8'h00, overflow_error: 1'b1};
                            count_next   = '0;
                            live_next    = '1;
                            matched_next = '0;
                            halted_next  = 1'b1;
                        end
                    end
                    OP_OTHER:
                    begin
                        if (count_reg != '0)
                        begin
                            if (matched_reg != '0)
                            begin
                                emit      = 1'b1;
                                emit_data = '{out_char: UPPER_A_BYTE + 8'(first_idx),
                                              overflow_error: 1'b0};
                            end
                            count_next   = '0;
                            live_next    = '1;
                            matched_next = '0;
                        end
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (cmd_pop)
        begin
            out_valid_next = emit;
            out_next       = emit_data;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            live_reg      <= '1;
            matched_reg   <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            live_reg      <= live_next;
            matched_reg   <= matched_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// ===== hw/rtl/nato_word_letter_decoder.sv =====
// ----------------------------------------------------------------------------
// nato_word_letter_decoder
// Turns a text stream of NATO code words into their upper-case initials.
// ----------------------------------------------------------------------------
//  channel   direction  beat        handshake
//  item      in         item_t      push / full
//  result    out        result_t    pop / empty
//
//  one byte per cycle sustained unless a result stalls; the back end handles
//  one command a cycle, set by its 26 parallel code word compares
//  commands pass through the queue, then results through the result register
//  reset is asynchronous, active low, and needs no clearing pass
//  a stalled result holds the back end; the two-entry queue absorbs the front
// ----------------------------------------------------------------------------
module nato_word_letter_decoder #(
    parameter int MAX_WORD_LETTERS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  nwld_pkg::item_t   item,
    output logic              full,
    input  logic              pop,
    output nwld_pkg::result_t result,
    output logic              empty
);

    import nwld_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    logic cmd_push;
    logic cmd_pop;
    logic fifo_full;
    logic fifo_empty;
    cmd_t cmd_in;
    cmd_t cmd_out;

    nwld_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .cmd_full (fifo_full),
        .full     (full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    nwld_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (cmd_push),
        .wr_data    (cmd_in),
        .fifo_full  (fifo_full),
        .rd_en      (cmd_pop),
        .rd_data    (cmd_out),
        .fifo_empty (fifo_empty)
    );

    nwld_back #(
        .MAX_WORD_LETTERS (MAX_WORD_LETTERS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (fifo_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !fifo_full)
        else $error("command queue written while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !fifo_empty)
        else $error("command queue read while empty");

    a_eot_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && item.end_of_text) |=> !fifo_empty)
        else $error("end of text beat lost before the back end");

    a_overflow_has_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.overflow_error) |-> (result.out_char == 8'h00))
        else $error("overflow result carries a character");

endmodule

// ===== tb/sv/nato_word_letter_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nato_word_letter_decoder_tb
// Self-checking bench for the code word decoder. Bytes go in through the
// push/full queue and decoded beats come back through pop/empty, each one
// checked against a local decoder model or a row of the short directed
// table, which runs first; then random word sequences under three idling mixes.
// ----------------------------------------------------------------------------
module nato_word_letter_decoder_tb;

    import nwld_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int MAX_LETTERS = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BYTES = 170;
    localparam int HOLD_CYCLES = 60;
    localparam int HOLD_AFTER  = 30;
    localparam int DRAIN_TAIL  = 8;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic [6:0] rep;
        logic       typed;
        logic       has;
        result_t    want;
    } stim_row_t;

    localparam result_t NO_BEAT   = '{out_char: 8'h00, overflow_error: 1'b0};
    localparam result_t NL_BEAT   = '{out_char: NEWLINE_BYTE, overflow_error: 1'b0};
    localparam result_t OVF_BEAT  = '{out_char: 8'h00, overflow_error: 1'b1};
    localparam result_t A_BEAT    = '{out_char: 8'h41, overflow_error: 1'b0};
    localparam result_t Z_BEAT    = '{out_char: 8'h5A, overflow_error: 1'b0};

    localparam int DIR_ROWS = 27;
    localparam stim_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{8'h40, 1'b0, 7'd1,  1'b1, 1'b0, NO_BEAT},
        '{8'h61, 1'b0, 7'd1,  1'b0, 1'b0, NO_BEAT},
        '{8'h4C, 1'b0, 7'd1,  1'b0, 1'b0, NO_BEAT},
        '{8'h66, 1'b0, 7'd1,  1'b0, 1'b0, NO_BEAT},
        '{8'h41, 1'b0, 7'd1,  1'b0, 1'b0, NO_BEAT},
        '{8'h60, 1'b0, 7'd1,  1'b1, 1'b1, A_BEAT},
        '{8'h5A, 1'b0, 7'd1,  1'b0, 1'b0, NO_BEAT},
        '{8'h75, 1'b0, 7'd1,  1'b0, 1'b0, NO_BEAT},
        '{8'h6C, 1'b0, 7'd1,  1'b0, 1'b0, NO_BEAT},
        '{8'h75, 1'b0, 7'd1,  1'b0, 1'b0, NO_BEAT},
        '{8'h78, 1'b0, 7'd1,  1'b0, 1'b0, NO_BEAT},
        '{8'h5B, 1'b0, 7'd1,  1'b1, 1'b1, Z_BEAT},
        '{8'h2F, 1'b0, 7'd1,  1'b1, 1'b1, NL_BEAT},
        '{8'h51, 1'b0, 7'd1,  1'b1, 1'b0, NO_BEAT},
        '{8'h2F, 1'b0, 7'd1,  1'b1, 1'b1, NL_BEAT},
        '{8'h2F, 1'b0, 7'd1,  1'b1, 1'b0, NO_BEAT},
        '{8'h65, 1'b0, 7'd1,  1'b0, 1'b0, NO_BEAT},
        '{8'h63, 1'b0, 7'd1,  1'b0, 1'b0, NO_BEAT},
        '{8'hFF, 1'b1, 7'd1,  1'b1, 1'b1, NL_BEAT},
        '{8'h7B, 1'b0, 7'd1,  1'b1, 1'b0, NO_BEAT},
        '{8'h78, 1'b0, 7'd63, 1'b1, 1'b0, NO_BEAT},
        '{8'h58, 1'b0, 7'd1,  1'b1, 1'b1, OVF_BEAT},
        '{8'h2F, 1'b0, 7'd1,  1'b1, 1'b0, NO_BEAT},
        '{8'h61, 1'b0, 7'd1,  1'b1, 1'b0, NO_BEAT},
        '{8'h00, 1'b1, 7'd1,  1'b1, 1'b1, NL_BEAT},
        '{8'h2F, 1'b0, 7'd1,  1'b1, 1'b1, NL_BEAT},
        '{8'h00, 1'b1, 7'd1,  1'b1, 1'b1, NL_BEAT}
    };

    string code_words [CODE_COUNT] = '{
        "ALFA", "BRAVO", "CHARLIE", "DELTA", "ECHO", "FOXTROT", "GOLF", "HOTEL",
        "INDIA", "JULIETT", "KILO", "LIMA", "MIKE", "NOVEMBER", "OSCAR", "PAPA",
        "QUEBEC", "ROMEO", "SIERRA", "TANGO", "UNIFORM", "VICTOR", "WHISKEY",
        "XRAY", "YANKEE", "ZULU"
    };

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    push  = 1'b0;
    item_t   item  = '0;
    logic    full;
    logic    pop   = 1'b0;
    result_t result;
    logic    empty;

    // decoder model state
    logic [6:0]            word_len;
    logic [CODE_COUNT-1:0] live_words;
    logic [CODE_COUNT-1:0] matched_words;
    logic                  skip_byte;
    logic                  halted;

    result_t due_results [$];
    int      send_idle_pct;
    int      recv_idle_pct;
    int      mismatches;
    int      bytes_sent;
    int      results_checked;
    int      letters_seen;
    int      newlines_seen;
    int      overflows_seen;

    nato_word_letter_decoder #(
        .MAX_WORD_LETTERS(MAX_LETTERS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (item),
        .full  (full),
        .pop   (pop),
        .result(result),
        .empty (empty)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= UPPER_A_BYTE && c <= UPPER_Z_BYTE) ||
               (c >= LOWER_A_BYTE && c <= LOWER_Z_BYTE);
    endfunction

    function automatic void clear_word();
        word_len      = '0;
        live_words    = '1;
        matched_words = '0;
    endfunction

    function automatic bit decode_byte(input item_t it, output result_t r);
        logic [7:0] cw;
        r = NO_BEAT;
        if (it.end_of_text)
        begin
            clear_word();
            skip_byte = 1'b0;
            halted    = 1'b0;
            r = NL_BEAT;
            return 1'b1;
        end
        if (halted)
            return 1'b0;
        if (skip_byte)
        begin
            skip_byte = 1'b0;
            return 1'b0;
        end
        if (it.in_char == SLASH_BYTE)
        begin
            skip_byte = 1'b1;
            r = NL_BEAT;
            return 1'b1;
        end
        if (is_letter(it.in_char))
        begin
            for (int x = 0; x < CODE_COUNT; x++)
            begin
                if (live_words[x])
                begin
                    if (int'(word_len) < code_words[x].len())
                    begin
                        cw = 8'(code_words[x][word_len]);
                        if ((it.in_char | CASE_BIT) == (cw | CASE_BIT))
                        begin
                            if (int'(word_len) + 1 == code_words[x].len())
                            begin
                                matched_words[x] = 1'b1;
                                live_words[x]    = 1'b0;
                            end
                        end
                        else
                        begin
                            live_words[x] = 1'b0;
                        end
                    end
                    else
                    begin
                        live_words[x] = 1'b0;
                    end
                end
            end
            word_len = word_len + 7'd1;
            if (int'(word_len) >= MAX_LETTERS)
            begin
                clear_word();
                halted = 1'b1;
                r = OVF_BEAT;
                return 1'b1;
            end
            return 1'b0;
        end
        if (word_len == '0)
            return 1'b0;
        for (int x = 0; x < CODE_COUNT; x++)
        begin
            if (matched_words[x])
            begin
                clear_word();
                r.out_char = 8'(code_words[x][0]);
                return 1'b1;
            end
        end
        clear_word();
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_result();
        result_t want;
        if (due_results.size() == 0)
        begin
            report_mismatch($sformatf("beat %h with nothing due", result));
        end
        else
        begin
            want = due_results.pop_front();
            if (result.out_char !== want.out_char)
                report_mismatch($sformatf("out_char %h, expected %h",
                                          result.out_char, want.out_char));
            if (result.overflow_error !== want.overflow_error)
                report_mismatch($sformatf("overflow_error %b, expected %b",
                                          result.overflow_error, want.overflow_error));
        end
        results_checked++;
        if (result.overflow_error === 1'b1)
            overflows_seen++;
        else if (result.out_char === NEWLINE_BYTE)
            newlines_seen++;
        else
            letters_seen++;
    endtask

    // drive one byte, wait for acceptance, then step the model
    task automatic send_item(input item_t it, output bit has, output result_t r);
        bit ignored;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        ignored = halted && !it.end_of_text;
        has = decode_byte(it, r);
        if (!ignored)
            bytes_sent++;
    endtask

    task automatic offer_byte(input logic [7:0] c, input logic eot);
        bit      has;
        result_t r;
        send_item('{in_char: c, end_of_text: eot}, has, r);
        if (has)
            due_results.push_back(r);
    endtask

    function automatic logic [7:0] random_letter();
        return ($urandom_range(0, 1) ? UPPER_A_BYTE : LOWER_A_BYTE) +
               8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] random_separator();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (is_letter(b) || b == SLASH_BYTE);
        return b;
    endfunction

    task automatic send_random_sequence();
        int         sel;
        int         x;
        int         n;
        int         k;
        logic [7:0] c;
        sel = $urandom_range(0, 99);
        if (sel < 70)
        begin
            x = $urandom_range(0, CODE_COUNT - 1);
            n = code_words[x].len();
            k = $urandom_range(0, 9);
            if (k < 2)
                n = $urandom_range(1, n - 1);
            for (int i = 0; i < n; i++)
            begin
                c = 8'(code_words[x][i]) | ($urandom_range(0, 1) ? CASE_BIT : 8'h00);
                offer_byte(c, 1'b0);
            end
            if (k >= 8)
                repeat ($urandom_range(1, 4)) offer_byte(random_letter(), 1'b0);
            k = $urandom_range(0, 19);
            if (k == 0)
                offer_byte(8'($urandom_range(0, 255)), 1'b1);
            else if (k < 3)
                offer_byte(SLASH_BYTE, 1'b0);
            else
                offer_byte(random_separator(), 1'b0);
        end
        else if (sel < 80)
        begin
            offer_byte(SLASH_BYTE, 1'b0);
            offer_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        else if (sel < 92)
        begin
            repeat ($urandom_range(1, 4)) offer_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        else if (sel < 98)
        begin
            offer_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        else
        begin
            // runaway word, then halted noise, then end of text
            repeat (MAX_LETTERS + $urandom_range(0, 3)) offer_byte(random_letter(), 1'b0);
            repeat ($urandom_range(0, 3)) offer_byte(8'($urandom_range(0, 255)), 1'b0);
            offer_byte(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // result side
    initial
    begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (pop && !empty)
                    check_result();
                if (!held && results_checked >= HOLD_AFTER)
                begin
                    hold_left = HOLD_CYCLES;
                    held      = 1'b1;
                end
                if (hold_left > 0)
                begin
                    hold_left--;
                    pop <= 1'b0;
                end
                else
                begin
                    pop <= ($urandom_range(0, 99) >= recv_idle_pct);
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        bit      has;
        result_t r;
        int      phase_goal;
        mismatches      = 0;
        bytes_sent      = 0;
        results_checked = 0;
        letters_seen    = 0;
        newlines_seen   = 0;
        overflows_seen  = 0;
        send_idle_pct   = 19;
        recv_idle_pct   = 80;
        clear_word();
        skip_byte = 1'b0;
        halted    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            repeat (DIRECTED_ROWS[i].rep)
            begin
                send_item('{in_char: DIRECTED_ROWS[i].ch, end_of_text: DIRECTED_ROWS[i].eot},
                          has, r);
                if (DIRECTED_ROWS[i].typed)
                begin
                    if (DIRECTED_ROWS[i].has)
                        due_results.push_back(DIRECTED_ROWS[i].want);
                end
                else if (has)
                begin
                    due_results.push_back(r);
                end
            end
        end

        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = (p == 0) ? 19 : (p == 1) ? 80 : 0;
            recv_idle_pct = (p == 0) ? 80 : (p == 1) ? 19 : 0;
            phase_goal = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_goal)
                send_random_sequence();
            // sender rests until the block has drained
            push <= 1'b0;
            while (due_results.size() != 0)
                @(posedge clk);
        end

        repeat (DRAIN_TAIL) @(posedge clk);
        $display("covered %0d bytes and %0d beats: %0d letters, %0d newlines, %0d overflows",
                 bytes_sent, results_checked, letters_seen, newlines_seen, overflows_seen);
        $display("idling mixes: sender-heavy, receiver-heavy, none; one long receiver hold-off");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
